>>> hdl/assert_macros.svh
// assertion macros shared by the sampler rtl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER_AT(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> hdl/cbps_pkg.sv
// shared widths, constants and types of the channel busy sampler
// no dependencies
package cbps_pkg;

  localparam int TIME_W  = 40;
  localparam int CNT_W   = 48;
  localparam int SHARE_W = 16;
  localparam int BUSY_W  = 10;
  localparam int MIN_W   = 16;

  localparam logic [BUSY_W-1:0] BUSY_MAX         = 10'd1000;
  localparam logic [MIN_W-1:0]  MIN_INTERVAL_RST = 16'd1000;

  // status of the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hdl/cbps_sdiv.sv
// bit-serial restoring divider, one quotient bit per cycle, saturated quotient
// depends on cbps_pkg and assert_macros.svh
`include "assert_macros.svh"

module cbps_sdiv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cbps_pkg::CNT_W-1:0]   dividend,
  input  logic [cbps_pkg::TIME_W-1:0]  divisor,
  output cbps_pkg::div_stat_t          stat,
  output logic [cbps_pkg::SHARE_W-1:0] quotient
);
  import cbps_pkg::*;

  localparam int STEP_W = $clog2(CNT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CNT_W - 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    dvd_r, dvd_nxt;
  logic [TIME_W-1:0]   dvs_r, dvs_nxt;
  logic [TIME_W-1:0]   rem_r, rem_nxt;
  logic [SHARE_W-1:0]  q_r, q_nxt;
  logic                ovf_r, ovf_nxt;

  logic [TIME_W:0]     trial;
  logic [TIME_W+1:0]   diff;
  logic                fits;

  // trial subtract of the shifted remainder
  assign trial = {rem_r, dvd_r[CNT_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};
  assign fits  = ~diff[TIME_W+1];

  // step sequencing and shift registers
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[CNT_W-2:0], 1'b0};
      rem_nxt = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      q_nxt   = {q_r[SHARE_W-2:0], fits};
      // any bit leaving the top means the quotient exceeds the share range
      ovf_nxt = ovf_r | q_r[SHARE_W-1];
      step_nxt = step_r + STEP_W'(1);
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
  end

  // saturated result
  assign quotient  = ovf_r ? {SHARE_W{1'b1}} : q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  `ASSERT_NEVER_AT(a_start_while_busy, clk, rst_n, start && busy_r, "divider started while busy")
  `ASSERT_AT(a_done_single, clk, rst_n, done_r |=> !done_r, "divider done held more than a cycle")
endmodule

>>> hdl/channel_busy_permille_sampler_unit.sv
// channel busy sampler top: apb register, baseline store, lane sequencer
// baseline and too-soon requests go from the check straight to the output register;
// a reported sample first runs the divider once per lane (tx, rx, ext), then the sum
// a new request is taken only once the result is loaded; 48-step divider per lane
// reset: synchronous active-low rst_n clears baseline, min interval to 1000, no output
// depends on cbps_pkg, cbps_sdiv and assert_macros.svh
`include "assert_macros.svh"

module channel_busy_permille_sampler_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cbps_pkg::TIME_W-1:0]  in_now_ms,
  input  logic [cbps_pkg::CNT_W-1:0]   in_tx_total_us,
  input  logic [cbps_pkg::CNT_W-1:0]   in_rx_total_us,
  input  logic [cbps_pkg::CNT_W-1:0]   in_ext_total_us,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_reported,
  output logic [cbps_pkg::BUSY_W-1:0]  out_busy_permille,
  output logic [cbps_pkg::SHARE_W-1:0] out_rx_share,
  output logic [cbps_pkg::SHARE_W-1:0] out_ext_share,
  output logic [cbps_pkg::SHARE_W-1:0] out_tx_share,
  // configuration port
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [2:0]                   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import cbps_pkg::*;

  localparam logic [0:0] REG_MIN_INTERVAL = 1'b0;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic [1:0] LANE_TX  = 2'd0;
  localparam logic [1:0] LANE_RX  = 2'd1;
  localparam logic [1:0] LANE_EXT = 2'd2;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          lane_r, lane_nxt;
  logic [MIN_W-1:0]    min_int_r;

  logic [TIME_W-1:0]   base_time_r, base_time_nxt;
  logic [CNT_W-1:0]    base_tx_r, base_tx_nxt;
  logic [CNT_W-1:0]    base_rx_r, base_rx_nxt;
  logic [CNT_W-1:0]    base_ext_r, base_ext_nxt;

  logic [TIME_W-1:0]   cur_now_r;
  logic [CNT_W-1:0]    cur_tx_r, cur_rx_r, cur_ext_r;
  logic [TIME_W-1:0]   interval_r, interval_nxt;
  logic [SHARE_W-1:0]  tx_sh_r, rx_sh_r, ext_sh_r;
  logic [SHARE_W-1:0]  tx_sh_nxt, rx_sh_nxt, ext_sh_nxt;
  logic                res_rep_r, res_rep_nxt;
  logic [BUSY_W-1:0]   res_busy_r, res_busy_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_rep_r;
  logic [BUSY_W-1:0]   out_busy_r;
  logic [SHARE_W-1:0]  out_tx_r, out_rx_r, out_ext_r;

  logic                in_acc, out_load, cfg_wr;
  logic [TIME_W:0]     gap;
  logic                too_soon;
  logic [CNT_W-1:0]    lane_cur, lane_base, delta;
  logic [CNT_W:0]      lane_diff;
  logic [SHARE_W+1:0]  busy_sum;
  logic                div_start;
  div_stat_t           div_stat;
  logic [SHARE_W-1:0]  div_q;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_MIN_INTERVAL);
  assign cfg_prdata = (cfg_paddr[2] == REG_MIN_INTERVAL) ? {16'd0, min_int_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_int_r <= MIN_INTERVAL_RST;
    end else if (cfg_wr) begin
      min_int_r <= cfg_pwdata[MIN_W-1:0];
    end
  end

  // elapsed time and minimum gap check
  assign gap      = {1'b0, cur_now_r} - {1'b0, base_time_r};
  assign too_soon = gap[TIME_W] || (gap[TIME_W-1:0] == '0)
                    || (gap[TIME_W-1:0] < {{(TIME_W-MIN_W){1'b0}}, min_int_r});

  // counter delta of the current lane, zero when the counter went backwards
  always_comb begin
    case (lane_r)
      LANE_TX: begin
        lane_cur  = cur_tx_r;
        lane_base = base_tx_r;
      end
      LANE_RX: begin
        lane_cur  = cur_rx_r;
        lane_base = base_rx_r;
      end
      LANE_EXT: begin
        lane_cur  = cur_ext_r;
        lane_base = base_ext_r;
      end
      default: begin
        lane_cur  = '0;
        lane_base = '0;
      end
    endcase
  end

  assign lane_diff = {1'b0, lane_cur} - {1'b0, lane_base};
  assign delta     = lane_diff[CNT_W] ? '0 : lane_diff[CNT_W-1:0];
  assign div_start = (state_r == ST_START);

  cbps_sdiv u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (delta),
    .divisor  (interval_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // busy share sum, clamped to BUSY_MAX in the sum state
  assign busy_sum = {2'b00, tx_sh_r} + {2'b00, rx_sh_r} + {2'b00, ext_sh_r};

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // request sequencer
  always_comb begin
    state_nxt     = state_r;
    lane_nxt      = lane_r;
    base_time_nxt = base_time_r;
    base_tx_nxt   = base_tx_r;
    base_rx_nxt   = base_rx_r;
    base_ext_nxt  = base_ext_r;
    interval_nxt  = interval_r;
    tx_sh_nxt     = tx_sh_r;
    rx_sh_nxt     = rx_sh_r;
    ext_sh_nxt    = ext_sh_r;
    res_rep_nxt   = res_rep_r;
    res_busy_nxt  = res_busy_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        res_rep_nxt  = 1'b0;
        res_busy_nxt = '0;
        interval_nxt = gap[TIME_W-1:0];
        lane_nxt     = LANE_TX;
        if (base_time_r == '0) begin
          // no baseline yet: take this request as baseline
          base_time_nxt = cur_now_r;
          base_tx_nxt   = cur_tx_r;
          base_rx_nxt   = cur_rx_r;
          base_ext_nxt  = cur_ext_r;
          state_nxt     = ST_FIN;
        end else if (too_soon) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          case (lane_r)
            LANE_TX:  tx_sh_nxt  = div_q;
            LANE_RX:  rx_sh_nxt  = div_q;
            LANE_EXT: ext_sh_nxt = div_q;
            default:  tx_sh_nxt  = tx_sh_r;
          endcase
          if (lane_r == LANE_EXT) begin
            state_nxt = ST_SUM;
          end else begin
            lane_nxt  = lane_r + 2'd1;
            state_nxt = ST_START;
          end
        end
      end
      ST_SUM: begin
        res_rep_nxt   = 1'b1;
        res_busy_nxt  = (busy_sum > {8'd0, BUSY_MAX}) ? BUSY_MAX : busy_sum[BUSY_W-1:0];
        base_time_nxt = cur_now_r;
        base_tx_nxt   = cur_tx_r;
        base_rx_nxt   = cur_rx_r;
        base_ext_nxt  = cur_ext_r;
        state_nxt     = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lane_r      <= LANE_TX;
      out_valid_r <= 1'b0;
      base_time_r <= '0;
      base_tx_r   <= '0;
      base_rx_r   <= '0;
      base_ext_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      lane_r      <= lane_nxt;
      out_valid_r <= out_valid_nxt;
      base_time_r <= base_time_nxt;
      base_tx_r   <= base_tx_nxt;
      base_rx_r   <= base_rx_nxt;
      base_ext_r  <= base_ext_nxt;
    end
  end

  // request capture and working payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_now_r <= in_now_ms;
      cur_tx_r  <= in_tx_total_us;
      cur_rx_r  <= in_rx_total_us;
      cur_ext_r <= in_ext_total_us;
    end
    interval_r <= interval_nxt;
    tx_sh_r    <= tx_sh_nxt;
    rx_sh_r    <= rx_sh_nxt;
    ext_sh_r   <= ext_sh_nxt;
    res_rep_r  <= res_rep_nxt;
    res_busy_r <= res_busy_nxt;
  end

  // output register, zero fields when nothing is reported
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rep_r  <= res_rep_r;
      out_busy_r <= res_busy_r;
      out_tx_r   <= res_rep_r ? tx_sh_r  : '0;
      out_rx_r   <= res_rep_r ? rx_sh_r  : '0;
      out_ext_r  <= res_rep_r ? ext_sh_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reported      = out_rep_r;
  assign out_busy_permille = out_busy_r;
  assign out_rx_share      = out_rx_r;
  assign out_ext_share     = out_ext_r;
  assign out_tx_share      = out_tx_r;

  `ASSERT_AT(a_accept_to_check, clk, rst_n, in_acc |=> (state_r == ST_CHECK), "accepted request not checked")
  `ASSERT_AT(a_quiet_zero, clk, rst_n, (out_valid_r && !out_rep_r) |-> ((out_busy_r == '0) && (out_tx_r == '0) && (out_rx_r == '0) && (out_ext_r == '0)), "unreported result has nonzero fields")
  `ASSERT_AT(a_busy_clamp, clk, rst_n, out_valid_r |-> (out_busy_r <= BUSY_MAX), "busy permille above clamp")
  `ASSERT_AT(a_div_in_seq, clk, rst_n, div_stat.busy |-> (state_r == ST_DIV), "divider busy out of sequence")
endmodule
